/* hw/rtl/gdms_pkg.sv */
// gdms_pkg: shared types and constants for the greedy dag memory scheduler
// used by gdms_store and greedy_dag_memory_scheduler; no dependencies
package gdms_pkg;

    localparam int MaxNodesDef = 64;
    localparam int ValW        = 31;
    localparam int SumW        = 38;
    localparam int OutSumW     = 37;
    localparam int IdxOutW     = 6;
    localparam int MaskInW     = 64;

    typedef struct packed {
        logic [ValW-1:0] out_mem;
        logic [ValW-1:0] run_mem;
        logic [ValW-1:0] time_cost;
    } t_rec;

endpackage

/* hw/rtl/greedy_dag_memory_scheduler.sv */
// greedy_dag_memory_scheduler: top level, node loading and scheduling sequencer
// depends on gdms_pkg and gdms_store
//
// Nodes load one per transaction (start high while busy is low).
// A transaction with i_last_node set starts scheduling, during which busy stays
// high. Each scheduling step makes one pass over the n stored nodes through the
// single table read port to find the ready node with the least key, then, when
// a predecessor output becomes free, a second pass subtracts the freed memory,
// then the pick itself, which emits the result. Each result is shown for one
// cycle with o_valid and cannot be stalled. The final result carries o_is_last,
// and the block is then ready for a new graph. A step that finds no ready node
// ends the schedule with a stuck result.
module greedy_dag_memory_scheduler import gdms_pkg::*; #(
    parameter int MAX_NODES = MaxNodesDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ValW-1:0]      i_out_mem,
    input  logic [ValW-1:0]      i_run_mem,
    input  logic [ValW-1:0]      i_time_cost,
    input  logic [MaskInW-1:0]   i_pred_mask,
    input  logic                 i_last_node,
    output logic                 o_valid,
    output logic [IdxOutW-1:0]   o_node_index,
    output logic [OutSumW-1:0]   o_total_time,
    output logic [OutSumW-1:0]   o_peak_memory,
    output logic                 o_stuck,
    output logic                 o_is_last
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] CntMax = CW'(MAX_NODES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEL  = 2'd1;
    localparam logic [1:0] S_SUB  = 2'd2;
    localparam logic [1:0] S_PICK = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_step, n_step;
    logic [CW-1:0]        r_addr, n_addr;
    logic                 r_rd_vld, n_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    logic [MAX_NODES-1:0] r_done, n_done;
    logic [MAX_NODES-1:0] r_live_mask, n_live_mask;
    logic [MAX_NODES-1:0] r_u, n_u;
    logic [MAX_NODES-1:0] r_free, n_free;
    logic [MAX_NODES-1:0] r_prev_pred, n_prev_pred;
    logic                 r_found, n_found;
    logic [SumW-1:0]      r_live, n_live;
    logic [SumW-1:0]      r_peak, n_peak;
    logic [SumW-1:0]      r_time, n_time;
    logic                 r_valid, n_valid;

    logic [IW-1:0]        r_best_idx, n_best_idx;
    t_rec                 r_best, n_best;
    logic [MAX_NODES-1:0] r_best_pred, n_best_pred;
    logic [IdxOutW-1:0]   r_o_idx, n_o_idx;
    logic                 r_o_stuck, n_o_stuck, r_o_last, n_o_last;

    logic                 w_accept, w_issue, w_wr_en, w_ready, w_better, w_scan_end;
    logic [MAX_NODES-1:0] w_valid_mask;
    logic [IW-1:0]        w_rd_addr;
    t_rec                 w_wr_rec, w_rd_rec;
    logic [MAX_NODES-1:0] w_rd_pred, w_free;
    logic [SumW-1:0]      w_live_add;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_wr_en  = w_accept && (r_count < CntMax);
    assign w_issue  = ((r_state == S_SEL) || (r_state == S_SUB)) && (r_addr < r_count);
    assign w_rd_addr = w_issue ? r_addr[IW-1:0] : '0;
    assign w_wr_rec = '{out_mem: i_out_mem, run_mem: i_run_mem, time_cost: i_time_cost};
    assign w_scan_end = (r_addr == r_count) && !r_rd_vld;

    always_comb begin
        for (int k = 0; k < MAX_NODES; k++) begin
            w_valid_mask[k] = (CW'(k) < r_count);
        end
    end

    gdms_store #(.MAX_NODES(MAX_NODES), .IW(IW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_rec  (w_wr_rec),
        .i_wr_pred (i_pred_mask[MAX_NODES-1:0]),
        .i_rd_addr (w_rd_addr),
        .o_rd_rec  (w_rd_rec),
        .o_rd_pred (w_rd_pred)
    );

    assign w_ready = !r_done[r_rd_idx] && ((w_rd_pred & w_valid_mask & ~r_done) == '0);
    assign w_better = !r_found || (w_rd_rec.out_mem < r_best.out_mem) ||
        ((w_rd_rec.out_mem == r_best.out_mem) && (w_rd_rec.run_mem < r_best.run_mem));
    assign w_free = r_prev_pred & w_valid_mask & r_live_mask & ~r_u;
    assign w_live_add = r_live + SumW'(r_best.out_mem);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_addr      = w_issue ? r_addr + CW'(1) : r_addr;
        n_rd_vld    = w_issue;
        n_done      = r_done;
        n_live_mask = r_live_mask;
        n_u         = r_u;
        n_free      = r_free;
        n_prev_pred = r_prev_pred;
        n_found     = r_found;
        n_live      = r_live;
        n_peak      = r_peak;
        n_time      = r_time;
        n_valid     = 1'b0;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_best_pred = r_best_pred;
        n_o_idx     = r_o_idx;
        n_o_stuck   = r_o_stuck;
        n_o_last    = r_o_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_wr_en) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_last_node) begin
                        n_state = S_SEL;
                        n_addr  = '0;
                        n_found = 1'b0;
                        n_u     = '0;
                    end
                end
            end
            S_SEL: begin
                if (r_rd_vld) begin
                    if (!r_done[r_rd_idx]) begin
                        n_u = r_u | w_rd_pred;
                    end
                    if (w_ready && w_better) begin
                        n_found     = 1'b1;
                        n_best_idx  = r_rd_idx;
                        n_best      = w_rd_rec;
                        n_best_pred = w_rd_pred;
                    end
                end
                if (w_scan_end) begin
                    n_addr = '0;
                    if (!r_found) begin
                        n_valid     = 1'b1;
                        n_o_idx     = '0;
                        n_o_stuck   = 1'b1;
                        n_o_last    = 1'b1;
                        n_state     = S_IDLE;
                        n_count     = '0;
                        n_step      = '0;
                        n_done      = '0;
                        n_live_mask = '0;
                        n_live      = '0;
                        n_peak      = '0;
                        n_time      = '0;
                        n_prev_pred = '0;
                    end else if (w_free != '0) begin
                        n_free      = w_free;
                        n_live_mask = r_live_mask & ~w_free;
                        n_state     = S_SUB;
                    end else begin
                        n_state = S_PICK;
                    end
                end
            end
            S_SUB: begin
                if (r_rd_vld && r_free[r_rd_idx]) begin
                    n_live = r_live - SumW'(w_rd_rec.out_mem);
                end
                if (w_scan_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_valid     = 1'b1;
                n_o_idx     = IdxOutW'(r_best_idx);
                n_o_stuck   = 1'b0;
                n_o_last    = (r_step + CW'(1) == r_count);
                n_time      = r_time + SumW'(r_best.time_cost);
                n_done      = r_done | (MAX_NODES'(1) << r_best_idx);
                n_prev_pred = r_best_pred;
                if (r_best.out_mem != '0) begin
                    n_live      = w_live_add;
                    n_live_mask = r_live_mask | (MAX_NODES'(1) << r_best_idx);
                    if (w_live_add > r_peak) begin
                        n_peak = w_live_add;
                    end
                end
                if (r_step + CW'(1) == r_count) begin
                    n_state     = S_IDLE;
                    n_count     = '0;
                    n_step      = '0;
                    n_done      = '0;
                    n_live_mask = '0;
                    n_live      = '0;
                    n_peak      = '0;
                    n_time      = '0;
                    n_prev_pred = '0;
                end else begin
                    n_state = S_SEL;
                    n_step  = r_step + CW'(1);
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_u     = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output snapshot of the updated sums, taken before the end-of-graph clear so they match the result
    logic [SumW-1:0] r_o_time, r_o_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_done      <= '0;
            r_live_mask <= '0;
            r_u         <= '0;
            r_free      <= '0;
            r_prev_pred <= '0;
            r_found     <= 1'b0;
            r_live      <= '0;
            r_peak      <= '0;
            r_time      <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_done      <= n_done;
            r_live_mask <= n_live_mask;
            r_u         <= n_u;
            r_free      <= n_free;
            r_prev_pred <= n_prev_pred;
            r_found     <= n_found;
            r_live      <= n_live;
            r_peak      <= n_peak;
            r_time      <= n_time;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= r_addr[IW-1:0];
        r_best_idx  <= n_best_idx;
        r_best      <= n_best;
        r_best_pred <= n_best_pred;
        r_o_idx     <= n_o_idx;
        r_o_stuck   <= n_o_stuck;
        r_o_last    <= n_o_last;
        if (n_valid) begin
            r_o_time <= (r_state == S_PICK) ? r_time + SumW'(r_best.time_cost) : r_time;
            r_o_peak <= ((r_state == S_PICK) && (r_best.out_mem != '0) &&
                         (w_live_add > r_peak)) ? w_live_add : r_peak;
        end
    end

    assign o_valid       = r_valid;
    assign o_node_index  = r_o_idx;
    assign o_total_time  = r_o_time[OutSumW-1:0];
    assign o_peak_memory = r_o_peak[OutSumW-1:0];
    assign o_stuck       = r_o_stuck;
    assign o_is_last     = r_o_last;

`ifndef SYNTHESIS
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_last |-> !busy)
        else $error("final result while still busy");
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |-> busy)
        else $error("intermediate result after schedule ended");
    a_stuck_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stuck |-> o_is_last && (o_node_index == '0))
        else $error("stuck result malformed");
    a_pick_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PICK |=> o_valid && !o_stuck)
        else $error("pick without result");
    a_sched_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_node |=> busy)
        else $error("schedule did not start");
`endif

endmodule

/* hw/rtl/gdms_store.sv */
// gdms_store: node tables (memory figures, time cost, predecessor masks)
// one write port and one registered read port; depends on gdms_pkg
module gdms_store import gdms_pkg::*; #(
    parameter int MAX_NODES = MaxNodesDef,
    parameter int IW        = $clog2(MAX_NODES)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_addr,
    input  t_rec                 i_wr_rec,
    input  logic [MAX_NODES-1:0] i_wr_pred,
    input  logic [IW-1:0]        i_rd_addr,
    output t_rec                 o_rd_rec,
    output logic [MAX_NODES-1:0] o_rd_pred
);

    t_rec                 r_rec_mem  [MAX_NODES];
    logic [MAX_NODES-1:0] r_pred_mem [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_rec_mem[i_wr_addr]  <= i_wr_rec;
            r_pred_mem[i_wr_addr] <= i_wr_pred;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_rec  <= r_rec_mem[i_rd_addr];
        o_rd_pred <= r_pred_mem[i_rd_addr];
    end

endmodule
